[hw/rtl/jhvd_pkg.sv]
// Package for the prefix-code value decoder: item structs, table line layout,
// kind/status/register codes and table sizing. No dependencies.
package jhvd_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;   // holds 0..TABLE_DEPTH
    localparam int MAX_PREFIX  = 32;

    // input kinds
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_BIT  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_VALUE   = 2'd0;
    localparam logic [1:0] STAT_OOB     = 2'd1;
    localparam logic [1:0] STAT_END     = 2'd2;
    localparam logic [1:0] STAT_NOMATCH = 2'd3;

    // configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_HAS_OOB     = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic               stream_bit;
        logic [5:0]         line_index;
        logic [5:0]         line_prefix_len;
        logic [31:0]        line_code;
        logic [5:0]         line_range_len;
        logic signed [31:0] line_range_low;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  prefix_len;
        logic [31:0] code;
        logic [5:0]  range_len;
        logic [31:0] range_low;
    } t_line;

endpackage

[hw/rtl/jbig2_huffman_value_decoder_unit.sv]
// Prefix-code value decoder top level: table memory, scan sequencer, output register.
// Depends on jhvd_pkg.
//
// Sequencing: a load or an inner offset bit is taken in IDLE. A prefix bit walks the lines in
// use in SCAN (one synchronous line read per cycle), then passes through HOLD when it ends in a
// result. The last offset bit goes through FIN (matched line re-read) and HOLD, a stream end to HOLD.
// Items are taken only in IDLE, so a new item waits until the scan of a prefix bit is done;
// HOLD keeps the input stalled while the output register is still occupied.
// Reset (synchronous, active low) clears the decode state and registers, not the line memory.
module jbig2_huffman_value_decoder_unit
    import jhvd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input items
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    // result items
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    // One-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,   // take items
        ST_SCAN = 4'b0010,   // walk the table for a prefix match
        ST_FIN  = 4'b0100,   // matched line re-read, form the value
        ST_HOLD = 4'b1000    // park a result until the output register frees
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [6:0] r_entry_count, n_entry_count;
    logic       r_has_oob, n_has_oob;

    // Decode state
    logic [31:0]      r_code, n_code;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_in_off, n_in_off;
    logic [IDX_W-1:0] r_match, n_match;
    logic [31:0]      r_off, n_off;
    logic [5:0]       r_left, n_left;

    // Scan pipeline
    logic [CNT_W-1:0] r_scan, n_scan;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    // Result staging and output register
    t_out_item r_res, n_res;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Line memory
    t_line            r_mem [TABLE_DEPTH];
    t_line            r_rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    t_line            wr_line;

    logic             in_acc;
    logic [CNT_W-1:0] n_use;
    logic [CNT_W-1:0] back;
    logic             hit;
    logic             is_oob_line;
    logic             is_lower;
    logic [5:0]       left_dec;
    logic             do_restart;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Lines in use: clamp the count to the memory depth
    assign n_use = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(r_entry_count);
    assign back  = r_has_oob ? CNT_W'(3) : CNT_W'(2);

    // Loads land only from IDLE; reads matter in SCAN and on the IDLE cycle that takes the last
    // offset bit, when no load is taken, so a load never meets a read whose data is used.
    assign wr_en   = in_acc && (i_in.kind == KIND_LINE)
                     && (32'(i_in.line_index) < 32'(TABLE_DEPTH));
    assign wr_addr = IDX_W'(i_in.line_index);
    assign wr_line = '{prefix_len: i_in.line_prefix_len,
                       code:       i_in.line_code,
                       range_len:  i_in.line_range_len,
                       range_low:  i_in.line_range_low};

    // In SCAN walk the table; otherwise keep the matched line on the port so the
    // last offset bit finds its range low registered in FIN.
    assign rd_addr = (r_state == ST_SCAN) ? r_scan[IDX_W-1:0] : r_match;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_line;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Compare the line read last cycle against the accumulated prefix
    assign hit = r_rd_vld && (r_rd_data.prefix_len == r_cnt)
                 && (r_rd_data.code == r_code);
    assign is_oob_line = r_has_oob && ({1'b0, r_rd_idx} == (n_use - CNT_W'(1)));
    // Lower-range line subtracts its offset
    assign is_lower = (n_use >= back) && ({1'b0, r_match} == (n_use - back));
    assign left_dec = (r_left != 6'd0) ? (r_left - 6'd1) : 6'd0;

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_has_oob     = r_has_oob;
        n_code        = r_code;
        n_cnt         = r_cnt;
        n_in_off      = r_in_off;
        n_match       = r_match;
        n_off         = r_off;
        n_left        = r_left;
        n_scan        = r_scan;
        n_rd_vld      = 1'b0;
        n_rd_idx      = r_rd_idx;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        do_restart    = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRY_COUNT: n_entry_count = i_cfg_data;
                CFG_HAS_OOB:     n_has_oob     = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        KIND_BIT: begin
                            if (r_in_off) begin
                                // shift in an offset bit; last one closes the value
                                n_off  = {r_off[30:0], i_in.stream_bit};
                                n_left = left_dec;
                                if (left_dec == 6'd0) begin
                                    n_state = ST_FIN;
                                end
                            end else begin
                                n_code  = {r_code[30:0], i_in.stream_bit};
                                n_cnt   = r_cnt + 6'd1;
                                n_scan  = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_END: begin
                            n_res      = '{status: STAT_END, value: '0};
                            do_restart = 1'b1;
                            n_state    = ST_HOLD;
                        end
                        default: ;   // loads go straight to memory; kind 3 drops
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (is_oob_line) begin
                        n_res      = '{status: STAT_OOB, value: '0};
                        do_restart = 1'b1;
                        n_state    = ST_HOLD;
                    end else if (r_rd_data.range_len == 6'd0) begin
                        // no offset bits: value is the range low itself
                        n_res      = '{status: STAT_VALUE, value: r_rd_data.range_low};
                        do_restart = 1'b1;
                        n_state    = ST_HOLD;
                    end else begin
                        n_match  = r_rd_idx;
                        n_off    = '0;
                        n_left   = r_rd_data.range_len;
                        n_in_off = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else if (r_scan < n_use) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan[IDX_W-1:0];
                    n_scan   = r_scan + CNT_W'(1);
                end else if (32'(r_cnt) >= 32'(MAX_PREFIX)) begin
                    n_res      = '{status: STAT_NOMATCH, value: '0};
                    do_restart = 1'b1;
                    n_state    = ST_HOLD;
                end else begin
                    n_state = ST_IDLE;   // wait for the next prefix bit
                end
            end
            ST_FIN: begin
                n_res.status = STAT_VALUE;
                n_res.value  = is_lower ? (r_rd_data.range_low - r_off)
                                        : (r_rd_data.range_low + r_off);
                do_restart   = 1'b1;
                n_state      = ST_HOLD;
            end
            ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // back to the prefix phase after any result
        if (do_restart) begin
            n_code   = '0;
            n_cnt    = '0;
            n_in_off = 1'b0;
            n_match  = '0;
            n_off    = '0;
            n_left   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_has_oob     <= 1'b0;
            r_code        <= '0;
            r_cnt         <= '0;
            r_in_off      <= 1'b0;
            r_match       <= '0;
            r_off         <= '0;
            r_left        <= '0;
            r_scan        <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_has_oob     <= n_has_oob;
            r_code        <= n_code;
            r_cnt         <= n_cnt;
            r_in_off      <= n_in_off;
            r_match       <= n_match;
            r_off         <= n_off;
            r_left        <= n_left;
            r_scan        <= n_scan;
            r_rd_vld      <= n_rd_vld;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // The prefix count never runs past the longest code
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(MAX_PREFIX))
        else $error("prefix bit count past limit");

    // While in the offset phase at least one offset bit is still owed
    a_off_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_off && (r_state == ST_IDLE)) |-> (r_left != 6'd0))
        else $error("offset phase with no bits left");

    // The scan pointer never passes the lines in use
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan <= n_use))
        else $error("scan pointer out of range");

    // A parked result leaves HOLD only into the output register
    a_hold_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HOLD) && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("result lost leaving hold");

    // Only value results carry a nonzero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != STAT_VALUE)) |-> (o_out.value == '0))
        else $error("nonzero value on non-value result");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for jbig2_huffman_value_decoder_unit: random prefix-code tables,
// coded bit streams and noise, checked against an in-bench decoder of the same table.
// Depends on jhvd_pkg and the decoder RTL.
module tb_top
    import jhvd_pkg::*;
();

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;   // one full line scan plus staging
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASE_ITEMS   = 60;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = CFG_ENTRY_COUNT;
    logic [6:0] i_cfg_data = '0;

    jbig2_huffman_value_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bench-side decoder: its own copy of the line table, registers and
    // decode state, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    logic [5:0]  dec_plen [TABLE_DEPTH];
    logic [31:0] dec_code [TABLE_DEPTH];
    logic [5:0]  dec_rlen [TABLE_DEPTH];
    logic [31:0] dec_low  [TABLE_DEPTH];
    logic [31:0] code_sr = '0;
    int          code_len = 0;
    bit          reading_offset = 1'b0;
    int          hit_line = 0;
    logic [31:0] offset_sr = '0;
    int          offset_todo = 0;
    int          reg_count = 0;
    bit          reg_oob = 1'b0;

    t_out_item   decode_due[$];     // decoded symbols still owed by the block
    t_in_item    item_backlog[$];   // beats waiting for the driver
    int          items_queued = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    // Stimulus-side view of the table, as loaded in push order.
    logic [5:0]  plan_plen [TABLE_DEPTH];
    logic [31:0] plan_code [TABLE_DEPTH];
    logic [5:0]  plan_rlen [TABLE_DEPTH];

    int          sweep_count [6] = '{0, 64, 3, 127, 1, 2};
    bit          sweep_oob   [6] = '{0, 1, 1, 0, 1, 0};

    function automatic int lines_used();
        return (reg_count > TABLE_DEPTH) ? TABLE_DEPTH : reg_count;
    endfunction

    function automatic void clear_decode();
        code_sr        = '0;
        code_len       = 0;
        reading_offset = 1'b0;
        hit_line       = 0;
        offset_sr      = '0;
        offset_todo    = 0;
    endfunction

    // Close a decode on the matched line; the lower-range line subtracts.
    function automatic t_out_item close_value();
        t_out_item r;
        int        n;
        int        back;
        n = lines_used();
        back = reg_oob ? 3 : 2;
        r.status = STAT_VALUE;
        if (n >= back && hit_line == n - back)
            r.value = dec_low[hit_line] - offset_sr;
        else
            r.value = dec_low[hit_line] + offset_sr;
        clear_decode();
        return r;
    endfunction

    function automatic void decode_step(input t_in_item it, output bit produced,
                                        output t_out_item res);
        int n;
        bit hit;
        produced = 1'b0;
        res = '0;
        n = lines_used();
        case (it.kind)
            KIND_LINE: begin
                dec_plen[it.line_index] = it.line_prefix_len;
                dec_code[it.line_index] = it.line_code;
                dec_rlen[it.line_index] = it.line_range_len;
                dec_low[it.line_index]  = it.line_range_low;
            end
            KIND_END: begin
                produced = 1'b1;
                res.status = STAT_END;
                clear_decode();
            end
            KIND_BIT: begin
                if (reading_offset) begin
                    // keep only the last 32 offset bits on long ranges
                    offset_sr = {offset_sr[30:0], it.stream_bit};
                    if (offset_todo > 0)
                        offset_todo--;
                    if (offset_todo == 0) begin
                        produced = 1'b1;
                        res = close_value();
                    end
                end else begin
                    code_sr = {code_sr[30:0], it.stream_bit};
                    code_len++;
                    hit = 1'b0;
                    // first line in use with equal length and code wins
                    for (int i = 0; i < n && !hit; i++) begin
                        if (int'(dec_plen[i]) == code_len && dec_code[i] == code_sr) begin
                            hit = 1'b1;
                            if (reg_oob && i == n - 1) begin
                                produced = 1'b1;
                                res.status = STAT_OOB;
                                clear_decode();
                            end else begin
                                hit_line = i;
                                offset_sr = '0;
                                offset_todo = int'(dec_rlen[i]);
                                if (offset_todo == 0) begin
                                    produced = 1'b1;
                                    res = close_value();
                                end else begin
                                    reading_offset = 1'b1;
                                end
                            end
                        end
                    end
                    if (!hit && code_len >= MAX_PREFIX) begin
                        produced = 1'b1;
                        res.status = STAT_NOMATCH;
                        clear_decode();
                    end
                end
            end
            default: ;   // unknown kind: drop silently
        endcase
    endfunction

    function automatic int unsigned pace(input bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present one beat from the backlog, hold it until it is
    // taken, then idle for the gap drawn when it was presented.
    // ------------------------------------------------------------------
    int unsigned in_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap != 0) begin
                i_in_valid <= 1'b0;
                in_gap     <= in_gap - 1;
            end else if (item_backlog.size() != 0) begin
                i_in       <= item_backlog.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= pace(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Advance the bench decoder on every accepted input beat.
    always @(posedge i_clk) begin : predict_beat
        bit        produced;
        t_out_item res;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decode_step(i_in, produced, res);
            if (produced)
                decode_due.push_back(res);
        end
    end

    // Result side: stall a drawn number of cycles after every taken beat.
    int unsigned out_stall = 0;

    always @(posedge i_clk) begin : result_pacing
        int unsigned stall_n;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else if (o_out_valid && i_out_ready) begin
            stall_n = pace(out_calm);
            out_stall   <= stall_n;
            i_out_ready <= (stall_n == 0);
        end else if (out_stall != 0) begin
            out_stall   <= out_stall - 1;
            i_out_ready <= (out_stall == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every taken result beat with the oldest owed symbol.
    always @(posedge i_clk) begin : check_result
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decode_due.size() == 0) begin
                $error("unexpected result beat: status %0d value %0d",
                       o_out.status, o_out.value);
                error_count = error_count + 1;
            end else begin
                want = decode_due.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_out.status);
                    error_count = error_count + 1;
                end
                if (o_out.value !== want.value) begin
                    $error("value mismatch: expected %0d, actual %0d",
                           want.value, o_out.value);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Fill every field at random so the block must ignore the unused ones.
    function automatic t_in_item scrambled();
        t_in_item it;
        it.kind            = KIND_UNUSED;
        it.stream_bit      = 1'($urandom_range(0, 1));
        it.line_index      = 6'($urandom_range(0, 63));
        it.line_prefix_len = 6'($urandom_range(0, 63));
        it.line_code       = $urandom;
        it.line_range_len  = 6'($urandom_range(0, 63));
        it.line_range_low  = $urandom;
        return it;
    endfunction

    task automatic push_load(input int idx, input logic [5:0] plen, input logic [31:0] code,
                             input logic [5:0] rlen, input logic [31:0] low);
        t_in_item it;
        it = scrambled();
        it.kind            = KIND_LINE;
        it.line_index      = 6'(idx);
        it.line_prefix_len = plen;
        it.line_code       = code;
        it.line_range_len  = rlen;
        it.line_range_low  = low;
        item_backlog.push_back(it);
        plan_plen[idx] = plen;
        plan_code[idx] = code;
        plan_rlen[idx] = rlen;
        items_queued++;
    endtask

    task automatic push_bit(input logic b);
        t_in_item it;
        it = scrambled();
        it.kind       = KIND_BIT;
        it.stream_bit = b;
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic push_end();
        t_in_item it;
        it = scrambled();
        it.kind = KIND_END;
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic push_unknown();
        item_backlog.push_back(scrambled());
    endtask

    function automatic logic [5:0] rand_rlen();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 4)
            return 6'd0;
        else if (r == 4)
            return 6'd32;
        else if (r == 5)
            return 6'($urandom_range(33, 63));   // long range: only low 32 bits kept
        else
            return 6'($urandom_range(1, 6));
    endfunction

    function automatic logic [31:0] rand_low();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // A line outside the prefix-free plan: dead (length 0), full 32-bit, or short random.
    task automatic push_junk_line(input int idx);
        int unsigned plen;
        case ($urandom_range(0, 2))
            0: push_load(idx, 6'd0, $urandom, rand_rlen(), rand_low());
            1: push_load(idx, 6'd32, $urandom, rand_rlen(), rand_low());
            default: begin
                plen = $urandom_range(1, 8);
                push_load(idx, 6'(plen), $urandom & ((32'd1 << plen) - 1),
                          rand_rlen(), rand_low());
            end
        endcase
    endtask

    // Canonical prefix-free code over n lines, lengths never falling; a few junk lines mixed in.
    task automatic build_table(input int n);
        int          len;
        logic [63:0] code;
        int          step;
        len = 1;
        while ((1 << len) < n + 1)
            len++;
        code = '0;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                step = ($urandom_range(0, 4) == 0 && len < MAX_PREFIX) ? 1 : 0;
                code = (code + 1) << step;
                len += step;
            end
            if ($urandom_range(0, 11) == 0)
                push_junk_line(i);
            else
                push_load(i, 6'(len), code[31:0], rand_rlen(), rand_low());
        end
    endtask

    // Send the code of one line MSB first, then its offset bits; now and then abandon it.
    task automatic push_sequence(input int line, input int n, input bit oob);
        int plen;
        int rlen;
        int cut;
        plen = int'(plan_plen[line]);
        rlen = int'(plan_rlen[line]);
        if (plen == 0 || plen > MAX_PREFIX) begin
            push_bit(1'($urandom_range(0, 1)));
            return;
        end
        if (oob && line == n - 1)
            rlen = 0;   // out-of-band carries no offset
        cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, plen + rlen - 1))
                                          : plen + rlen;
        for (int k = 0; k < plen + rlen; k++) begin
            if (k == cut) begin
                push_end();
                return;
            end
            if (k < plen)
                push_bit(plan_code[line][plen - 1 - k]);
            else
                push_bit(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic set_reg(input logic idx, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENTRY_COUNT)
            reg_count = int'(data);
        else
            reg_oob = data[0];
    endtask

    // Hold off until every beat is taken and every symbol returned, then let a scan drain.
    task automatic settle();
        do
            @(posedge i_clk);
        while (item_backlog.size() != 0 || i_in_valid || decode_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input bit oob);
        int n;
        int first;
        int unsigned pick;
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        set_reg(CFG_ENTRY_COUNT, 7'(count));
        set_reg(CFG_HAS_OOB, 7'(oob));
        n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        build_table(n);
        first = items_queued;
        while (items_queued - first < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 8 && n > 0) begin
                push_sequence($urandom_range(0, n - 1), n, oob);
            end else if (pick == 8) begin
                case ($urandom_range(0, 3))
                    0: push_bit(1'($urandom_range(0, 1)));
                    1: push_end();
                    2: push_unknown();
                    default: push_junk_line($urandom_range(0, TABLE_DEPTH - 1));
                endcase
            end else begin
                push_bit(1'($urandom_range(0, 1)));
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int random_start;
        int sweep;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            dec_plen[i] = '0;
            dec_code[i] = '0;
            dec_rlen[i] = '0;
            dec_low[i]  = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: four lines, out-of-band on the last, line 1 is the lower range.
        set_reg(CFG_ENTRY_COUNT, 7'd4);
        set_reg(CFG_HAS_OOB, 7'd1);
        push_end();                                   // stream end while idle
        push_unknown();                               // unknown kind: no result
        push_load(0, 6'd1, 32'h0, 6'd0, 32'h7fff_ffff);
        push_load(1, 6'd2, 32'h2, 6'd2, 32'h8000_0000);
        push_load(2, 6'd3, 32'h6, 6'd3, 32'hffff_fffb);
        push_load(3, 6'd3, 32'h7, 6'd0, 32'h0);
        push_bit(1'b0);                               // zero range: value on last prefix bit
        push_bit(1'b1); push_bit(1'b0);               // lower range, wraps below min
        push_bit(1'b1); push_bit(1'b1);
        push_bit(1'b1); push_bit(1'b1); push_bit(1'b0);
        push_bit(1'b1); push_bit(1'b0); push_bit(1'b1);
        push_bit(1'b1); push_bit(1'b1); push_bit(1'b1); // out-of-band line
        push_bit(1'b1);                               // abandon mid-prefix
        push_end();
        settle();

        // Random: sweep the register extremes first, then random sizes.
        random_start = items_queued;
        sweep = 0;
        while (items_queued - random_start < RANDOM_ITEMS) begin
            if (sweep < 6)
                run_phase(sweep_count[sweep], sweep_oob[sweep]);
            else
                run_phase($urandom_range(4, 24), 1'($urandom_range(0, 1)));
            sweep++;
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
